[rtl/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// shared constants for the triangle circumcircle unit
// ----------------------------------------------------------------------------
package tcc_pkg;

   // width of every result field but the flag
   localparam int RESULT_WIDTH = 32;

   // root bits produced by the square root, enough for a 65 bit radicand
   localparam int ROOT_BITS = 34;

   // saturation limits of the signed centre and the unsigned radius
   localparam logic [RESULT_WIDTH-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [RESULT_WIDTH-1:0] SAT_NEG = 32'h8000_0000;
   localparam logic [RESULT_WIDTH-1:0] SAT_RAD = 32'hFFFF_FFFF;

endpackage

[rtl/tcc_req_if.sv]
// ----------------------------------------------------------------------------
// tcc_req_if
// valid/ready channel carrying one triangle per item
// ----------------------------------------------------------------------------
interface tcc_req_if #(
   parameter int COORD_WIDTH = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] first_x;
   logic signed [COORD_WIDTH-1:0] first_y;
   logic signed [COORD_WIDTH-1:0] second_x;
   logic signed [COORD_WIDTH-1:0] second_y;
   logic signed [COORD_WIDTH-1:0] third_x;
   logic signed [COORD_WIDTH-1:0] third_y;

   modport source (
      output valid, first_x, first_y, second_x, second_y, third_x, third_y,
      input  ready
   );
   modport sink (
      input  valid, first_x, first_y, second_x, second_y, third_x, third_y,
      output ready
   );
endinterface

[rtl/tcc_rsp_if.sv]
// ----------------------------------------------------------------------------
// tcc_rsp_if
// valid/ready channel carrying one circumcircle per item
// ----------------------------------------------------------------------------
interface tcc_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [tcc_pkg::RESULT_WIDTH-1:0] centre_x;
   logic signed [tcc_pkg::RESULT_WIDTH-1:0] centre_y;
   logic        [tcc_pkg::RESULT_WIDTH-1:0] circle_radius;
   logic                                    degenerate;

   modport source (
      output valid, centre_x, centre_y, circle_radius, degenerate,
      input  ready
   );
   modport sink (
      input  valid, centre_x, centre_y, circle_radius, degenerate,
      output ready
   );
endinterface

[rtl/triangle_circumcircle_unit.sv]
// ----------------------------------------------------------------------------
// triangle_circumcircle_unit
// circumcentre and circumradius of a triangle by determinants
// ----------------------------------------------------------------------------
// Takes one triangle per cycle and returns its circumcentre (b/2a, -c/2a)
// and radius, where a is the orientation determinant and b, c the lifted
// determinants. Coordinates are signed fixed point; the scale cancels, so
// the centre keeps the input fraction bits and comes out as a saturated
// signed 32 bit value, the radius as a saturated unsigned 32 bit value.
// Quotients truncate toward zero, the radius is the floor of the root.
// Collinear vertices raise degenerate and zero the other fields.
// Throughput is one item per clock. Stages, in order: five stages form the
// determinants, one restoring divider stage per quotient bit
// (3*COORD_WIDTH + 2), four stages form the squared distance, 34 square
// root stages and an output register. All stages advance together; a stalled
// output holds the whole pipe and drops req_chan.ready.
// ----------------------------------------------------------------------------
module triangle_circumcircle_unit #(
   parameter int COORD_WIDTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   tcc_req_if.sink    req_chan,
   tcc_rsp_if.source  rsp_chan
);

   localparam int W   = COORD_WIDTH;
   localparam int NB  = 3 * W + 2;            // quotient bits
   localparam int DNW = 2 * W + 3;            // divisor 2|a|
   localparam int RW  = DNW + 1;              // partial remainder
   localparam int XW  = (NB > 34) ? NB : 34;  // widened quotient magnitude
   localparam int EW  = XW + 2;               // centre minus first vertex
   localparam int RB  = tcc_pkg::ROOT_BITS;
   localparam int OW  = tcc_pkg::RESULT_WIDTH;

   // whole pipe moves when the output slot is free or being taken
   logic adv;
   logic out_valid_ff;
   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   logic take;
   assign take = req_chan.valid && adv;

   // ---------------- stage 1: squared norms and edge deltas ----------------
   logic signed [2*W-1:0] xx0_in, yy0_in, xx1_in, yy1_in, xx2_in, yy2_in;
   assign xx0_in = req_chan.first_x  * req_chan.first_x;
   assign yy0_in = req_chan.first_y  * req_chan.first_y;
   assign xx1_in = req_chan.second_x * req_chan.second_x;
   assign yy1_in = req_chan.second_y * req_chan.second_y;
   assign xx2_in = req_chan.third_x  * req_chan.third_x;
   assign yy2_in = req_chan.third_y  * req_chan.third_y;

   logic              v1_ff;
   logic [2*W-1:0]    s0_ff, s1_ff, s2_ff;
   logic signed [W:0] d2x_ff, d2y_ff, d3x_ff, d3y_ff;
   logic signed [W-1:0] x0_1_ff, y0_1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= take;
      end
      if (adv) begin
         s0_ff   <= $unsigned(xx0_in) + $unsigned(yy0_in);
         s1_ff   <= $unsigned(xx1_in) + $unsigned(yy1_in);
         s2_ff   <= $unsigned(xx2_in) + $unsigned(yy2_in);
         d2x_ff  <= $signed({req_chan.second_x[W-1], req_chan.second_x})
                  - $signed({req_chan.first_x[W-1],  req_chan.first_x});
         d2y_ff  <= $signed({req_chan.second_y[W-1], req_chan.second_y})
                  - $signed({req_chan.first_y[W-1],  req_chan.first_y});
         d3x_ff  <= $signed({req_chan.third_x[W-1],  req_chan.third_x})
                  - $signed({req_chan.first_x[W-1],  req_chan.first_x});
         d3y_ff  <= $signed({req_chan.third_y[W-1],  req_chan.third_y})
                  - $signed({req_chan.first_y[W-1],  req_chan.first_y});
         x0_1_ff <= req_chan.first_x;
         y0_1_ff <= req_chan.first_y;
      end
   end

   // ---------------- stage 2: lifted deltas ----------------
   logic                v2_ff;
   logic signed [2*W:0] sd2_ff, sd3_ff;
   logic signed [W:0]   d2x_2_ff, d2y_2_ff, d3x_2_ff, d3y_2_ff;
   logic signed [W-1:0] x0_2_ff, y0_2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         sd2_ff   <= $signed({1'b0, s1_ff}) - $signed({1'b0, s0_ff});
         sd3_ff   <= $signed({1'b0, s2_ff}) - $signed({1'b0, s0_ff});
         d2x_2_ff <= d2x_ff;
         d2y_2_ff <= d2y_ff;
         d3x_2_ff <= d3x_ff;
         d3y_2_ff <= d3y_ff;
         x0_2_ff  <= x0_1_ff;
         y0_2_ff  <= y0_1_ff;
      end
   end

   // ---------------- stage 3: cross products ----------------
   logic                  v3_ff;
   logic signed [2*W+1:0] ap1_ff, ap2_ff;
   logic signed [3*W+1:0] bp1_ff, bp2_ff, cp1_ff, cp2_ff;
   logic signed [W-1:0]   x0_3_ff, y0_3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         ap1_ff  <= d2x_2_ff * d3y_2_ff;
         ap2_ff  <= d3x_2_ff * d2y_2_ff;
         bp1_ff  <= sd2_ff * d3y_2_ff;
         bp2_ff  <= sd3_ff * d2y_2_ff;
         cp1_ff  <= sd2_ff * d3x_2_ff;
         cp2_ff  <= sd3_ff * d2x_2_ff;
         x0_3_ff <= x0_2_ff;
         y0_3_ff <= y0_2_ff;
      end
   end

   // ---------------- stage 4: determinants ----------------
   logic                  v4_ff;
   logic signed [2*W+2:0] a_ff;
   logic signed [3*W+2:0] b_ff, c_ff;
   logic signed [W-1:0]   x0_4_ff, y0_4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         a_ff    <= $signed({ap1_ff[2*W+1], ap1_ff}) - $signed({ap2_ff[2*W+1], ap2_ff});
         b_ff    <= $signed({bp1_ff[3*W+1], bp1_ff}) - $signed({bp2_ff[3*W+1], bp2_ff});
         c_ff    <= $signed({cp1_ff[3*W+1], cp1_ff}) - $signed({cp2_ff[3*W+1], cp2_ff});
         x0_4_ff <= x0_3_ff;
         y0_4_ff <= y0_3_ff;
      end
   end

   // ---------------- stage 5: magnitudes and signs, divider entry ----------
   logic [2*W+2:0] am_in;
   logic [3*W+2:0] bm_in, cm_in;
   assign am_in = a_ff[2*W+2] ? (~a_ff + 1'b1) : a_ff;
   assign bm_in = b_ff[3*W+2] ? (~b_ff + 1'b1) : b_ff;
   assign cm_in = c_ff[3*W+2] ? (~c_ff + 1'b1) : c_ff;

   // divider pipe, index 0 is its input, index NB its output
   logic                dv_ff    [0:NB];
   logic [DNW-1:0]      den_ff   [0:NB];
   logic [NB-1:0]       nx_ff    [0:NB];
   logic [NB-1:0]       ny_ff    [0:NB];
   logic [RW-2:0]       rx_ff    [0:NB];
   logic [RW-2:0]       ry_ff    [0:NB];
   logic [NB-1:0]       qx_ff    [0:NB];
   logic [NB-1:0]       qy_ff    [0:NB];
   logic                negx_ff  [0:NB];
   logic                negy_ff  [0:NB];
   logic                dg_ff    [0:NB];
   logic signed [W-1:0] x0d_ff   [0:NB];
   logic signed [W-1:0] y0d_ff   [0:NB];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v4_ff;
      end
      if (adv) begin
         den_ff[0]  <= {am_in[2*W+1:0], 1'b0};
         nx_ff[0]   <= bm_in[NB-1:0];
         ny_ff[0]   <= cm_in[NB-1:0];
         rx_ff[0]   <= '0;
         ry_ff[0]   <= '0;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         negx_ff[0] <= b_ff[3*W+2] ^ a_ff[2*W+2];
         negy_ff[0] <= ~c_ff[3*W+2] ^ a_ff[2*W+2];
         dg_ff[0]   <= (a_ff == '0);
         x0d_ff[0]  <= x0_4_ff;
         y0d_ff[0]  <= y0_4_ff;
      end
   end

   // ---------------- restoring divider, one quotient bit per stage ---------
   for (genvar j = 0; j < NB; j++) begin : g_div
      logic [RW-1:0] shx_in, shy_in, rxn_in, ryn_in;
      logic          gex_in, gey_in;

      assign shx_in = {rx_ff[j], nx_ff[j][NB-1-j]};
      assign shy_in = {ry_ff[j], ny_ff[j][NB-1-j]};
      assign gex_in = shx_in >= {1'b0, den_ff[j]};
      assign gey_in = shy_in >= {1'b0, den_ff[j]};
      assign rxn_in = gex_in ? (shx_in - {1'b0, den_ff[j]}) : shx_in;
      assign ryn_in = gey_in ? (shy_in - {1'b0, den_ff[j]}) : shy_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         if (adv) begin
            den_ff[j+1]  <= den_ff[j];
            nx_ff[j+1]   <= nx_ff[j];
            ny_ff[j+1]   <= ny_ff[j];
            rx_ff[j+1]   <= rxn_in[RW-2:0];
            ry_ff[j+1]   <= ryn_in[RW-2:0];
            qx_ff[j+1]   <= {qx_ff[j][NB-2:0], gex_in};
            qy_ff[j+1]   <= {qy_ff[j][NB-2:0], gey_in};
            negx_ff[j+1] <= negx_ff[j];
            negy_ff[j+1] <= negy_ff[j];
            dg_ff[j+1]   <= dg_ff[j];
            x0d_ff[j+1]  <= x0d_ff[j];
            y0d_ff[j+1]  <= y0d_ff[j];
         end
      end
   end

   // ---------------- E1: signed centre, saturation, offset to vertex -------
   logic [XW-1:0]        qxw_in, qyw_in;
   logic signed [EW-1:0] qsx_in, qsy_in;
   assign qxw_in = XW'(qx_ff[NB]);
   assign qyw_in = XW'(qy_ff[NB]);
   assign qsx_in = negx_ff[NB] ? -$signed({2'b00, qxw_in}) : $signed({2'b00, qxw_in});
   assign qsy_in = negy_ff[NB] ? -$signed({2'b00, qyw_in}) : $signed({2'b00, qyw_in});

   logic                 e1v_ff, e1dg_ff;
   logic signed [EW-1:0] ex_ff, ey_ff;
   logic [OW-1:0]        cx1_ff, cy1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1v_ff <= 1'b0;
      end else if (adv) begin
         e1v_ff <= dv_ff[NB];
      end
      if (adv) begin
         ex_ff   <= qsx_in - EW'(x0d_ff[NB]);
         ey_ff   <= qsy_in - EW'(y0d_ff[NB]);
         cx1_ff  <= (qxw_in > XW'(tcc_pkg::SAT_POS))
                  ? (negx_ff[NB] ? tcc_pkg::SAT_NEG : tcc_pkg::SAT_POS) : qsx_in[OW-1:0];
         cy1_ff  <= (qyw_in > XW'(tcc_pkg::SAT_POS))
                  ? (negy_ff[NB] ? tcc_pkg::SAT_NEG : tcc_pkg::SAT_POS) : qsy_in[OW-1:0];
         e1dg_ff <= dg_ff[NB];
      end
   end

   // ---------------- E2: offset magnitudes ----------------
   logic [EW-1:0] exm_in, eym_in;
   assign exm_in = ex_ff[EW-1] ? (~ex_ff + 1'b1) : ex_ff;
   assign eym_in = ey_ff[EW-1] ? (~ey_ff + 1'b1) : ey_ff;

   logic          e2v_ff, e2dg_ff, e2big_ff;
   logic [OW-1:0] exm_ff, eym_ff, cx2_ff, cy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e2v_ff <= 1'b0;
      end else if (adv) begin
         e2v_ff <= e1v_ff;
      end
      if (adv) begin
         exm_ff   <= exm_in[OW-1:0];
         eym_ff   <= eym_in[OW-1:0];
         e2big_ff <= (|exm_in[EW-1:OW]) || (|eym_in[EW-1:OW]);
         cx2_ff   <= cx1_ff;
         cy2_ff   <= cy1_ff;
         e2dg_ff  <= e1dg_ff;
      end
   end

   // ---------------- E3: squares ----------------
   logic            e3v_ff, e3dg_ff, e3big_ff;
   logic [2*OW-1:0] px_ff, py_ff;
   logic [OW-1:0]   cx3_ff, cy3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e3v_ff <= 1'b0;
      end else if (adv) begin
         e3v_ff <= e2v_ff;
      end
      if (adv) begin
         px_ff    <= (2*OW)'(exm_ff) * (2*OW)'(exm_ff);
         py_ff    <= (2*OW)'(eym_ff) * (2*OW)'(eym_ff);
         e3big_ff <= e2big_ff;
         cx3_ff   <= cx2_ff;
         cy3_ff   <= cy2_ff;
         e3dg_ff  <= e2dg_ff;
      end
   end

   // ---------------- E4: radicand, square root entry ----------------
   // root pipe, index 0 is its input, index RB its output
   logic                sv_ff   [0:RB];
   logic [2*RB-3:0]     rem_ff  [0:RB];
   logic [RB-1:0]       root_ff [0:RB];
   logic                sbig_ff [0:RB];
   logic                sdg_ff  [0:RB];
   logic [OW-1:0]       scx_ff  [0:RB];
   logic [OW-1:0]       scy_ff  [0:RB];

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= e3v_ff;
      end
      if (adv) begin
         rem_ff[0]  <= (2*RB-2)'({1'b0, px_ff} + {1'b0, py_ff});
         root_ff[0] <= '0;
         sbig_ff[0] <= e3big_ff;
         sdg_ff[0]  <= e3dg_ff;
         scx_ff[0]  <= cx3_ff;
         scy_ff[0]  <= cy3_ff;
      end
   end

   // ---------------- square root, one root bit per stage ----------------
   // rem holds radicand minus root squared; trial term is 2*root*2^i + 4^i
   for (genvar k = 0; k < RB; k++) begin : g_sqrt
      localparam int BI = RB - 1 - k;
      logic [2*RB-1:0] cand_in;
      logic            fit_in;

      assign cand_in = ((2*RB)'(root_ff[k]) << (BI + 1)) | ((2*RB)'(1) << (2 * BI));
      assign fit_in  = cand_in <= (2*RB)'(rem_ff[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sv_ff[k+1] <= sv_ff[k];
         end
         if (adv) begin
            rem_ff[k+1]  <= fit_in ? (rem_ff[k] - cand_in[2*RB-3:0]) : rem_ff[k];
            root_ff[k+1] <= fit_in ? (root_ff[k] | (RB'(1) << BI)) : root_ff[k];
            sbig_ff[k+1] <= sbig_ff[k];
            sdg_ff[k+1]  <= sdg_ff[k];
            scx_ff[k+1]  <= scx_ff[k];
            scy_ff[k+1]  <= scy_ff[k];
         end
      end
   end

   // ---------------- output register ----------------
   logic [OW-1:0] rad_in;
   assign rad_in = (sbig_ff[RB] || (|root_ff[RB][RB-1:OW]))
                 ? tcc_pkg::SAT_RAD : root_ff[RB][OW-1:0];

   logic [OW-1:0] cx_out_ff, cy_out_ff, rad_out_ff;
   logic          dg_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= sv_ff[RB];
      end
      if (adv) begin
         // collinear vertices give an all-zero circle
         cx_out_ff  <= sdg_ff[RB] ? '0 : scx_ff[RB];
         cy_out_ff  <= sdg_ff[RB] ? '0 : scy_ff[RB];
         rad_out_ff <= sdg_ff[RB] ? '0 : rad_in;
         dg_out_ff  <= sdg_ff[RB];
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.centre_x      = $signed(cx_out_ff);
   assign rsp_chan.centre_y      = $signed(cy_out_ff);
   assign rsp_chan.circle_radius = rad_out_ff;
   assign rsp_chan.degenerate    = dg_out_ff;

   // ---------------- checks ----------------
   // a degenerate item carries an all-zero circle
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.degenerate |->
         rsp_chan.centre_x == '0 && rsp_chan.centre_y == '0 &&
         rsp_chan.circle_radius == '0)
      else $error("degenerate item with nonzero circle");

   // a held result must freeze the input side
   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input accepted while output stalled");

   // a held result keeps its radius
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> $stable(rad_out_ff) && out_valid_ff)
      else $error("stalled result changed");

endmodule
